// File: sv/mcqc_pkg.sv
package mcqc_pkg;

    localparam int DEF_CHANNELS    = 5;
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int NUM_POS         = 5;
    localparam int PORT_WIDTH      = 16;
    localparam int POS_WIDTH       = 4;
    localparam int MASK_WIDTH      = 5;
    localparam int CHAN_WIDTH      = 3;
    localparam int PULSE_WIDTH     = 32;
    localparam int REG_IDX_WIDTH   = 3;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } t_dir;

    typedef enum logic [REG_IDX_WIDTH-1:0] {
        REG_BITPOS_CH0 = 3'd0,
        REG_BITPOS_CH1 = 3'd1,
        REG_BITPOS_CH2 = 3'd2,
        REG_BITPOS_CH3 = 3'd3,
        REG_BITPOS_CH4 = 3'd4,
        REG_CH_ENABLE  = 3'd5,
        REG_DIV4_MASK  = 3'd6
    } t_reg_idx;

    localparam logic [MASK_WIDTH-1:0] RST_ENABLE_MASK = 5'd31;
    localparam logic [MASK_WIDTH-1:0] RST_DIV4_MASK   = 5'd2;

    typedef struct packed {
        logic                  opcode;
        logic [PORT_WIDTH-1:0] port_word;
        logic [CHAN_WIDTH-1:0] channel;
    } t_in_word;

    typedef struct packed {
        logic [CHAN_WIDTH-1:0]  read_channel;
        logic                   channel_enabled;
        logic [1:0]             direction;
        logic [PULSE_WIDTH-1:0] pulse_count;
    } t_out_word;

    typedef struct packed {
        logic [REG_IDX_WIDTH-1:0] reg_index;
        logic [MASK_WIDTH-1:0]    wr_data;
    } t_cfg_word;

    // Per-channel command from the decode stage.
    typedef struct packed {
        logic inc_right;
        logic inc_left;
        logic rd;
        logic div4;
    } t_chan_cmd;

    function automatic logic [POS_WIDTH-1:0] rst_pos(input int c);
        return POS_WIDTH'(2 * c);
    endfunction

endpackage

// File: sv/mcqc_in_if.sv
interface mcqc_in_if;
    logic               valid;
    logic               ready;
    mcqc_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/mcqc_out_if.sv
interface mcqc_out_if;
    logic                valid;
    logic                ready;
    mcqc_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/mcqc_cfg_if.sv
interface mcqc_cfg_if;
    logic                valid;
    logic                ready;
    mcqc_pkg::t_cfg_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/multi_channel_quadrature_counter.sv
// Channel  Direction  Handshake     Word
// i_in     sink       valid/ready   opcode, port_word, channel
// o_res    source     valid/ready   read_channel, channel_enabled, direction, pulse_count
// i_cfg    sink       valid/ready   reg_index, wr_data (always ready)
//
// An accepted word is registered, then decoded and applied to the counters: one word per
// cycle is sustained unless a read stalls; a read result goes from r_s1 into r_out.
// The per-channel compare and subtract of the counters sets the cycle time.
// A stalled result holds the output register; samples still pass, and a read waits in
// the input register. Synchronous reset restores the register defaults and zero counts.
module multi_channel_quadrature_counter #(
    parameter int CHANNELS    = mcqc_pkg::DEF_CHANNELS,
    parameter int COUNT_WIDTH = mcqc_pkg::DEF_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcqc_in_if.sink     i_in,
    mcqc_out_if.source  o_res,
    mcqc_cfg_if.sink    i_cfg
);

    logic [mcqc_pkg::POS_WIDTH-1:0]  r_pos [mcqc_pkg::NUM_POS];
    logic [mcqc_pkg::MASK_WIDTH-1:0] r_en_mask;
    logic [mcqc_pkg::MASK_WIDTH-1:0] r_div4_mask;
    logic [mcqc_pkg::PORT_WIDTH-1:0] r_last;

    logic                r_s1_valid;
    mcqc_pkg::t_in_word  r_s1;
    logic                r_out_valid;
    mcqc_pkg::t_out_word r_out;
    mcqc_pkg::t_out_word n_out;

    logic                            out_free;
    logic                            is_read;
    logic                            s1_go;
    logic [mcqc_pkg::PORT_WIDTH-1:0] a0;
    logic [mcqc_pkg::PORT_WIDTH-1:0] a1;
    logic [mcqc_pkg::PORT_WIDTH-1:0] fwd;
    logic [mcqc_pkg::PORT_WIDTH-1:0] back;
    logic                            sel_en;
    logic [1:0]                      sel_dir;
    logic [COUNT_WIDTH-1:0]          sel_diff;

    mcqc_pkg::t_chan_cmd    cmd  [CHANNELS];
    logic [1:0]             dir  [CHANNELS];
    logic [COUNT_WIDTH-1:0] diff [CHANNELS];

    assign out_free    = !r_out_valid || o_res.ready;
    assign is_read     = r_s1.opcode == mcqc_pkg::OP_READ;
    assign s1_go       = r_s1_valid && (!is_read || out_free);
    assign i_in.ready  = !r_s1_valid || s1_go;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Line A of the port is line B shifted down by one.
    assign a0   = {1'b0, r_last[mcqc_pkg::PORT_WIDTH-1:1]};
    assign a1   = {1'b0, r_s1.port_word[mcqc_pkg::PORT_WIDTH-1:1]};
    assign fwd  = (r_last ^ a1) & ~(a0 ^ r_s1.port_word);
    assign back = (a0 ^ r_s1.port_word) & ~(r_last ^ a1);

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        always_comb begin
            cmd[c].inc_right = s1_go && !is_read && r_en_mask[c] && fwd[r_pos[c]];
            cmd[c].inc_left  = s1_go && !is_read && r_en_mask[c] && back[r_pos[c]];
            cmd[c].rd        = s1_go && is_read && r_en_mask[c]
                               && (r_s1.channel == mcqc_pkg::CHAN_WIDTH'(c));
            cmd[c].div4      = r_div4_mask[c];
        end

        mcqc_chan #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd[c]),
            .o_dir   (dir[c]),
            .o_diff  (diff[c])
        );
    end

    always_comb begin
        sel_en   = 1'b0;
        sel_dir  = mcqc_pkg::DIR_NONE;
        sel_diff = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if ((r_s1.channel == mcqc_pkg::CHAN_WIDTH'(c)) && r_en_mask[c]) begin
                sel_en   = 1'b1;
                sel_dir  = dir[c];
                sel_diff = diff[c];
            end
        end
        n_out.read_channel    = r_s1.channel;
        n_out.channel_enabled = sel_en;
        n_out.direction       = sel_dir;
        n_out.pulse_count     = mcqc_pkg::PULSE_WIDTH'(sel_diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go && !is_read) begin
                r_last <= r_s1.port_word;
            end
            if (s1_go && is_read) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1 <= i_in.data;
        end
        if (s1_go && is_read) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < mcqc_pkg::NUM_POS; c++) begin
                r_pos[c] <= mcqc_pkg::rst_pos(c);
            end
            r_en_mask   <= mcqc_pkg::RST_ENABLE_MASK;
            r_div4_mask <= mcqc_pkg::RST_DIV4_MASK;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                mcqc_pkg::REG_BITPOS_CH0, mcqc_pkg::REG_BITPOS_CH1,
                mcqc_pkg::REG_BITPOS_CH2, mcqc_pkg::REG_BITPOS_CH3,
                mcqc_pkg::REG_BITPOS_CH4: begin
                    for (int c = 0; c < mcqc_pkg::NUM_POS; c++) begin
                        if (i_cfg.data.reg_index == mcqc_pkg::REG_IDX_WIDTH'(c)) begin
                            r_pos[c] <= i_cfg.data.wr_data[mcqc_pkg::POS_WIDTH-1:0];
                        end
                    end
                end
                mcqc_pkg::REG_CH_ENABLE: begin
                    r_en_mask <= i_cfg.data.wr_data;
                end
                mcqc_pkg::REG_DIV4_MASK: begin
                    r_div4_mask <= i_cfg.data.wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    a_dir_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.direction != mcqc_pkg::DIR_NONE) |-> r_out.pulse_count != '0)
        else $error("result reports a rotation with zero count");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.channel_enabled
        |-> (r_out.direction == mcqc_pkg::DIR_NONE) && (r_out.pulse_count == '0))
        else $error("disabled channel read carries nonzero fields");

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && is_read |=> r_out_valid)
        else $error("read word left no result");

endmodule

// File: sv/mcqc_chan.sv
module mcqc_chan #(
    parameter int COUNT_WIDTH = mcqc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mcqc_pkg::t_chan_cmd    i_cmd,
    output logic [1:0]             o_dir,
    output logic [COUNT_WIDTH-1:0] o_diff
);

    logic [COUNT_WIDTH-1:0] r_right;
    logic [COUNT_WIDTH-1:0] r_left;
    logic                   gt;
    logic                   lt;
    logic                   clear;

    always_comb begin
        gt     = r_right > r_left;
        lt     = r_right < r_left;
        o_diff = '0;
        o_dir  = mcqc_pkg::DIR_NONE;
        clear  = 1'b0;
        if (gt) begin
            o_diff = r_right - r_left;
            if (!i_cmd.div4 || (o_diff[1:0] == 2'b00)) begin
                o_dir = mcqc_pkg::DIR_RIGHT;
                clear = 1'b1;
            end
        end else if (lt) begin
            o_diff = r_left - r_right;
            o_dir  = mcqc_pkg::DIR_LEFT;
            clear  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= '0;
            r_left  <= '0;
        end else if (i_cmd.rd && clear) begin
            r_right <= '0;
            r_left  <= '0;
        end else if (i_cmd.inc_right) begin
            r_right <= r_right + COUNT_WIDTH'(1);
        end else if (i_cmd.inc_left) begin
            r_left <= r_left + COUNT_WIDTH'(1);
        end
    end

endmodule
